// File: src/vlc_pkg.sv
// ----------------------------------------------------------------------------
// vlc_pkg
// Shared types and codes for the vector length clamp.
// ----------------------------------------------------------------------------
package vlc_pkg;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_MAX  = 2'd1,
        ACT_MIN  = 2'd2
    } t_act;

    typedef struct packed {
        logic valid;
        t_act act;
    } t_ctrl;

    localparam logic CFG_MIN_LENGTH = 1'b0;
    localparam logic CFG_MAX_LENGTH = 1'b1;

endpackage

// File: src/vlc_prep.sv
// ----------------------------------------------------------------------------
// vlc_prep
// Four front stages: magnitude and square, length squared, bound compare,
// scaled numerator mag^2 * target^2 per lane.
// ----------------------------------------------------------------------------
module vlc_prep #(
    parameter int W = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [2:0][W-1:0]            i_raw,
    input  logic [2*W-3:0]               i_min_sq,
    input  logic [2*W-3:0]               i_max_sq,
    output vlc_pkg::t_ctrl               o_ctrl,
    output logic [2*W-1:0]               o_len2,
    output logic [2:0][W-1:0]            o_raw,
    output logic [2:0]                   o_neg,
    output logic [2:0][4*W-3:0]          o_n
);
    localparam int PW = 4 * W - 2;

    logic [2:0][W-1:0]   w_mag;

    logic                r1_valid, r2_valid;
    logic [2:0][W-1:0]   r1_raw, r2_raw, r3_raw;
    logic [2:0]          r1_neg, r2_neg, r3_neg;
    logic [2:0][2*W-1:0] r1_sq, r2_sq, r3_sq;
    logic [2*W-1:0]      r2_len2, r3_len2;
    vlc_pkg::t_ctrl      r3_ctrl, r4_ctrl;
    logic [2*W-3:0]      r3_tsq;
    logic [2*W-1:0]      r4_len2;
    logic [2:0][W-1:0]   r4_raw;
    logic [2:0]          r4_neg;
    logic [2:0][PW-1:0]  r4_n;

    vlc_pkg::t_ctrl      n3_ctrl;
    logic [2*W-3:0]      n3_tsq;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = i_raw[l][W-1] ? (~i_raw[l] + W'(1)) : i_raw[l];
        end
    end

    always_comb begin
        n3_ctrl.valid = r2_valid;
        n3_ctrl.act   = vlc_pkg::ACT_NONE;
        n3_tsq        = '0;
        if (r2_len2 != '0) begin
            if (r2_len2 > {2'b00, i_max_sq}) begin
                n3_ctrl.act = vlc_pkg::ACT_MAX;
                n3_tsq      = i_max_sq;
            end else if (r2_len2 < {2'b00, i_min_sq}) begin
                n3_ctrl.act = vlc_pkg::ACT_MIN;
                n3_tsq      = i_min_sq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
            r3_ctrl.valid <= 1'b0;
            r4_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_ctrl  <= n3_ctrl;
            r4_ctrl  <= r3_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r1_raw[l] <= i_raw[l];
                r1_neg[l] <= i_raw[l][W-1];
                r1_sq[l]  <= (2*W)'(w_mag[l]) * (2*W)'(w_mag[l]);
                r4_n[l]   <= PW'(r3_sq[l]) * PW'(r3_tsq);
            end
            r2_raw  <= r1_raw;
            r2_neg  <= r1_neg;
            r2_sq   <= r1_sq;
            r2_len2 <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            r3_raw  <= r2_raw;
            r3_neg  <= r2_neg;
            r3_sq   <= r2_sq;
            r3_len2 <= r2_len2;
            r3_tsq  <= n3_tsq;
            r4_raw  <= r3_raw;
            r4_neg  <= r3_neg;
            r4_len2 <= r3_len2;
        end
    end

    assign o_ctrl = r4_ctrl;
    assign o_len2 = r4_len2;
    assign o_raw  = r4_raw;
    assign o_neg  = r4_neg;
    assign o_n    = r4_n;
endmodule

// File: src/vlc_root_stage.sv
// ----------------------------------------------------------------------------
// vlc_root_stage
// One bit of the scaled magnitude for all three lanes. Keeps P = k^2*len2
// and Q = k*len2 so each trial bit needs only shifts, adds and one compare.
// ----------------------------------------------------------------------------
module vlc_root_stage #(
    parameter int W   = 16,
    parameter int BIT = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  vlc_pkg::t_ctrl               i_ctrl,
    input  logic [2*W-1:0]               i_len2,
    input  logic [2:0][W-1:0]            i_raw,
    input  logic [2:0]                   i_neg,
    input  logic [2:0][4*W-3:0]          i_n,
    input  logic [2:0][4*W-3:0]          i_p,
    input  logic [2:0][4*W-3:0]          i_q,
    input  logic [2:0][W-2:0]            i_k,
    output vlc_pkg::t_ctrl               o_ctrl,
    output logic [2*W-1:0]               o_len2,
    output logic [2:0][W-1:0]            o_raw,
    output logic [2:0]                   o_neg,
    output logic [2:0][4*W-3:0]          o_n,
    output logic [2:0][4*W-3:0]          o_p,
    output logic [2:0][4*W-3:0]          o_q,
    output logic [2:0][W-2:0]            o_k
);
    localparam int PW = 4 * W - 2;

    logic [PW-1:0]      w_len2;
    logic [2:0][PW-1:0] w_try;
    logic [2:0][PW-1:0] n_p, n_q;
    logic [2:0][W-2:0]  n_k;

    vlc_pkg::t_ctrl     r_ctrl;
    logic [2*W-1:0]     r_len2;
    logic [2:0][W-1:0]  r_raw;
    logic [2:0]         r_neg;
    logic [2:0][PW-1:0] r_n, r_p, r_q;
    logic [2:0][W-2:0]  r_k;

    assign w_len2 = PW'(i_len2);

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_try[l] = i_p[l] + (i_q[l] << (BIT + 1)) + (w_len2 << (2 * BIT));
            n_p[l]   = i_p[l];
            n_q[l]   = i_q[l];
            n_k[l]   = i_k[l];
            if (w_try[l] <= i_n[l]) begin
                n_p[l]      = w_try[l];
                n_q[l]      = i_q[l] + (w_len2 << BIT);
                n_k[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len2 <= i_len2;
            r_raw  <= i_raw;
            r_neg  <= i_neg;
            r_n    <= i_n;
            r_p    <= n_p;
            r_q    <= n_q;
            r_k    <= n_k;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_len2 = r_len2;
    assign o_raw  = r_raw;
    assign o_neg  = r_neg;
    assign o_n    = r_n;
    assign o_p    = r_p;
    assign o_q    = r_q;
    assign o_k    = r_k;
endmodule

// File: src/vector_length_clamp_core.sv
// ----------------------------------------------------------------------------
// vector_length_clamp_core
// Rescales a nonzero 3D fixed-point vector so its length lies between min and max.
// ----------------------------------------------------------------------------
// Takes one vector per cycle while no valid output is stalled: four front
// stages form the length squared, compare it with the squared bounds and
// build each lane's numerator, then one stage per magnitude bit
// (COMP_WIDTH - 1) finds the scaled magnitude, and a last stage restores
// the sign into the output register. When a valid output is stalled the
// whole pipeline holds. A written bound passes through its length register
// and then its squared-bound register before the compare sees it.
module vector_length_clamp_core #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COMP_WIDTH-1:0] i_in_x,
    input  logic signed [COMP_WIDTH-1:0] i_in_y,
    input  logic signed [COMP_WIDTH-1:0] i_in_z,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [COMP_WIDTH-2:0]        i_cfg_data,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COMP_WIDTH-1:0] o_out_x,
    output logic signed [COMP_WIDTH-1:0] o_out_y,
    output logic signed [COMP_WIDTH-1:0] o_out_z,
    output logic [1:0]                   o_action
);
    localparam int W  = COMP_WIDTH;
    localparam int PW = 4 * W - 2;
    localparam int NS = W - 1;

    logic [W-2:0]        r_min_length, r_max_length;
    logic [2*W-3:0]      r_min_sq, r_max_sq;

    logic                w_en;
    logic [2:0][W-1:0]   w_in_raw;

    vlc_pkg::t_ctrl      w_ctrl [NS+1];
    logic [2*W-1:0]      w_len2 [NS+1];
    logic [2:0][W-1:0]   w_raw  [NS+1];
    logic [2:0]          w_neg  [NS+1];
    logic [2:0][PW-1:0]  w_n    [NS+1];
    logic [2:0][PW-1:0]  w_p    [NS+1];
    logic [2:0][PW-1:0]  w_q    [NS+1];
    logic [2:0][W-2:0]   w_k    [NS+1];

    logic [2:0][W-1:0]   n_out;
    logic                r_out_valid;
    logic [2:0][W-1:0]   r_out;
    vlc_pkg::t_act       r_out_act;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;
    assign w_in_raw = {$unsigned(i_in_z), $unsigned(i_in_y), $unsigned(i_in_x)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= '0;
            r_max_length <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vlc_pkg::CFG_MIN_LENGTH: r_min_length <= i_cfg_data;
                vlc_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_sq <= (2*W-2)'(r_min_length) * (2*W-2)'(r_min_length);
        r_max_sq <= (2*W-2)'(r_max_length) * (2*W-2)'(r_max_length);
    end

    vlc_prep #(.W(W)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_raw    (w_in_raw),
        .i_min_sq (r_min_sq),
        .i_max_sq (r_max_sq),
        .o_ctrl   (w_ctrl[0]),
        .o_len2   (w_len2[0]),
        .o_raw    (w_raw[0]),
        .o_neg    (w_neg[0]),
        .o_n      (w_n[0])
    );

    assign w_p[0] = '0;
    assign w_q[0] = '0;
    assign w_k[0] = '0;

    for (genvar s = 0; s < NS; s++) begin : g_root
        vlc_root_stage #(.W(W), .BIT(W - 2 - s)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[s]),
            .i_len2  (w_len2[s]),
            .i_raw   (w_raw[s]),
            .i_neg   (w_neg[s]),
            .i_n     (w_n[s]),
            .i_p     (w_p[s]),
            .i_q     (w_q[s]),
            .i_k     (w_k[s]),
            .o_ctrl  (w_ctrl[s+1]),
            .o_len2  (w_len2[s+1]),
            .o_raw   (w_raw[s+1]),
            .o_neg   (w_neg[s+1]),
            .o_n     (w_n[s+1]),
            .o_p     (w_p[s+1]),
            .o_q     (w_q[s+1]),
            .o_k     (w_k[s+1])
        );
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (w_ctrl[NS].act == vlc_pkg::ACT_NONE) begin
                n_out[l] = w_raw[NS][l];
            end else if (w_neg[NS][l]) begin
                n_out[l] = ~{1'b0, w_k[NS][l]} + W'(1);
            end else begin
                n_out[l] = {1'b0, w_k[NS][l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ctrl[NS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out     <= n_out;
            r_out_act <= w_ctrl[NS].act;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_out_x  = $signed(r_out[0]);
    assign o_out_y  = $signed(r_out[1]);
    assign o_out_z  = $signed(r_out[2]);
    assign o_action = r_out_act;
endmodule
